>>> src/rgb2yuv_pkg.sv
// Shared types, constants and register codes of the RGB to planar YUV 4:2:0 converter.
`default_nettype none

package rgb2yuv_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 2048;
    localparam int unsigned MAX_ROWS_DEF  = 2048;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam int unsigned COMP_W       = 8;
    localparam int unsigned DIM_W        = 12;
    localparam int unsigned INDEX_W      = 23;
    localparam int unsigned LUMA_CNT_W   = 23;
    localparam int unsigned CHROMA_CNT_W = 21;
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 23;
    localparam int unsigned SUM_W        = 16;

    localparam logic [SUM_W-1:0] COEF_Y_R   = 16'd66;
    localparam logic [SUM_W-1:0] COEF_Y_G   = 16'd129;
    localparam logic [SUM_W-1:0] COEF_Y_B   = 16'd25;
    localparam logic [SUM_W-1:0] COEF_CB_R  = 16'd38;
    localparam logic [SUM_W-1:0] COEF_CB_G  = 16'd74;
    localparam logic [SUM_W-1:0] COEF_CB_B  = 16'd112;
    localparam logic [SUM_W-1:0] COEF_CR_R  = 16'd112;
    localparam logic [SUM_W-1:0] COEF_CR_G  = 16'd94;
    localparam logic [SUM_W-1:0] COEF_CR_B  = 16'd18;
    localparam logic [SUM_W-1:0] CHROMA_OFS = 16'd32768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH = 3'd0,
        CFG_ROW_COUNT   = 3'd1,
        CFG_LUMA_BASE   = 3'd2,
        CFG_CB_BASE     = 3'd3,
        CFG_CR_BASE     = 3'd4
    } cfg_addr_t;

    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [COMP_W-1:0]  luma;
        logic [INDEX_W-1:0] luma_index;
        logic               chroma_valid;
        logic [COMP_W-1:0]  chroma_blue;
        logic [COMP_W-1:0]  chroma_red;
        logic [INDEX_W-1:0] cb_index;
        logic [INDEX_W-1:0] cr_index;
        logic               last_pixel;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   row_count;
        logic [INDEX_W-1:0] luma_base;
        logic [INDEX_W-1:0] cb_base;
        logic [INDEX_W-1:0] cr_base;
    } cfg_t;

    typedef struct packed {
        pixel_t             pix;
        logic [INDEX_W-1:0] luma_index;
        logic               chroma_valid;
        logic [INDEX_W-1:0] cb_index;
        logic [INDEX_W-1:0] cr_index;
        logic               last_pixel;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

>>> src/rgb2yuv_front.sv
// Front end: accepts pixels, tracks raster position and computes plane write indices.
`default_nettype none

module rgb2yuv_front #(
    parameter int unsigned MAX_WIDTH = rgb2yuv_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = rgb2yuv_pkg::MAX_ROWS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rgb2yuv_pkg::cfg_t   cfg,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rgb2yuv_pkg::pixel_t s_data,
    input  wire logic                push_ready,
    output logic                     push_valid,
    output rgb2yuv_pkg::entry_t      push_data
);

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
    localparam int unsigned WCMP_W = ($clog2(MAX_WIDTH + 1) > rgb2yuv_pkg::DIM_W) ?
                                     $clog2(MAX_WIDTH + 1) : rgb2yuv_pkg::DIM_W;
    localparam int unsigned RCMP_W = ($clog2(MAX_ROWS + 1) > rgb2yuv_pkg::DIM_W) ?
                                     $clog2(MAX_ROWS + 1) : rgb2yuv_pkg::DIM_W;

    logic [COL_W-1:0]                     column_reg;
    logic [COL_W-1:0]                     column_next;
    logic                                 second_row_reg;
    logic                                 second_row_next;
    logic [ROW_W-1:0]                     rows_done_reg;
    logic [ROW_W-1:0]                     rows_done_next;
    logic [rgb2yuv_pkg::LUMA_CNT_W-1:0]   luma_count_reg;
    logic [rgb2yuv_pkg::LUMA_CNT_W-1:0]   luma_count_next;
    logic [rgb2yuv_pkg::CHROMA_CNT_W-1:0] chroma_count_reg;
    logic [rgb2yuv_pkg::CHROMA_CNT_W-1:0] chroma_count_next;

    logic [WCMP_W-1:0] fw_ext;
    logic [WCMP_W-1:0] width_lim;
    logic [RCMP_W-1:0] rc_ext;
    logic [RCMP_W-1:0] rows_lim;
    logic              row_end;
    logic              frame_end;
    logic              chroma;
    logic              accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        fw_ext = WCMP_W'(cfg.frame_width);
        if (fw_ext == '0) begin
            width_lim = WCMP_W'(1);
        end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
            width_lim = WCMP_W'(MAX_WIDTH);
        end else begin
            width_lim = fw_ext;
        end
        rc_ext = RCMP_W'(cfg.row_count);
        if (rc_ext == '0) begin
            rows_lim = RCMP_W'(1);
        end else if (rc_ext > RCMP_W'(MAX_ROWS)) begin
            rows_lim = RCMP_W'(MAX_ROWS);
        end else begin
            rows_lim = rc_ext;
        end
    end

    assign row_end   = (WCMP_W'(column_reg) + WCMP_W'(1)) >= width_lim;
    assign frame_end = row_end && ((RCMP_W'(rows_done_reg) + RCMP_W'(1)) >= rows_lim);
    assign chroma    = !second_row_reg && !column_reg[0];

    always_comb begin
        push_data.pix          = s_data;
        push_data.luma_index   = cfg.luma_base + luma_count_reg;
        push_data.chroma_valid = chroma;
        push_data.last_pixel   = frame_end;
        if (chroma) begin
            push_data.cb_index = cfg.cb_base + rgb2yuv_pkg::INDEX_W'(chroma_count_reg);
            push_data.cr_index = cfg.cr_base + rgb2yuv_pkg::INDEX_W'(chroma_count_reg);
        end else begin
            push_data.cb_index = '0;
            push_data.cr_index = '0;
        end
    end

    always_comb begin
        column_next       = column_reg;
        second_row_next   = second_row_reg;
        rows_done_next    = rows_done_reg;
        luma_count_next   = luma_count_reg;
        chroma_count_next = chroma_count_reg;
        if (accept) begin
            if (frame_end) begin
                column_next       = '0;
                second_row_next   = 1'b0;
                rows_done_next    = '0;
                luma_count_next   = '0;
                chroma_count_next = '0;
            end else begin
                luma_count_next = luma_count_reg + 1'b1;
                if (chroma) begin
                    chroma_count_next = chroma_count_reg + 1'b1;
                end
                if (row_end) begin
                    column_next     = '0;
                    second_row_next = !second_row_reg;
                    rows_done_next  = rows_done_reg + 1'b1;
                end else begin
                    column_next = column_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg       <= '0;
            second_row_reg   <= 1'b0;
            rows_done_reg    <= '0;
            luma_count_reg   <= '0;
            chroma_count_reg <= '0;
        end else begin
            column_reg       <= column_next;
            second_row_reg   <= second_row_next;
            rows_done_reg    <= rows_done_next;
            luma_count_reg   <= luma_count_next;
            chroma_count_reg <= chroma_count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rgb2yuv_fifo.sv
// Small register queue between the front end and the color math.
`default_nettype none

module rgb2yuv_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = rgb2yuv_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output rgb2yuv_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rgb2yuv_back.sv
// Back end: color matrix stage followed by the result register.
`default_nettype none

module rgb2yuv_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire rgb2yuv_pkg::entry_t q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rgb2yuv_pkg::result_t     m_data
);

    logic                  s1_valid_reg;
    rgb2yuv_pkg::entry_t   s1_entry_reg;
    rgb2yuv_pkg::sum_t     s1_y_reg;
    rgb2yuv_pkg::sum_t     s1_cb_reg;
    rgb2yuv_pkg::sum_t     s1_cr_reg;
    logic                  out_valid_reg;
    rgb2yuv_pkg::result_t  out_data_reg;
    rgb2yuv_pkg::result_t  out_data_next;

    rgb2yuv_pkg::sum_t r_ext;
    rgb2yuv_pkg::sum_t g_ext;
    rgb2yuv_pkg::sum_t b_ext;
    rgb2yuv_pkg::sum_t y_sum;
    rgb2yuv_pkg::sum_t cb_sum;
    rgb2yuv_pkg::sum_t cr_sum;
    logic              out_free;
    logic              s1_move;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign q_pop    = q_valid && (!s1_valid_reg || out_free);

    // All sums stay within 16 bits; the chroma offset keeps the chroma sums non-negative.
    always_comb begin
        r_ext  = rgb2yuv_pkg::SUM_W'(q_data.pix.red);
        g_ext  = rgb2yuv_pkg::SUM_W'(q_data.pix.green);
        b_ext  = rgb2yuv_pkg::SUM_W'(q_data.pix.blue);
        y_sum  = rgb2yuv_pkg::COEF_Y_R * r_ext + rgb2yuv_pkg::COEF_Y_G * g_ext
               + rgb2yuv_pkg::COEF_Y_B * b_ext;
        cb_sum = rgb2yuv_pkg::CHROMA_OFS + rgb2yuv_pkg::COEF_CB_B * b_ext
               - rgb2yuv_pkg::COEF_CB_R * r_ext - rgb2yuv_pkg::COEF_CB_G * g_ext;
        cr_sum = rgb2yuv_pkg::CHROMA_OFS + rgb2yuv_pkg::COEF_CR_R * r_ext
               - rgb2yuv_pkg::COEF_CR_G * g_ext - rgb2yuv_pkg::COEF_CR_B * b_ext;
    end

    always_comb begin
        out_data_next.luma         = s1_y_reg[rgb2yuv_pkg::SUM_W-1:rgb2yuv_pkg::COMP_W];
        out_data_next.luma_index   = s1_entry_reg.luma_index;
        out_data_next.chroma_valid = s1_entry_reg.chroma_valid;
        out_data_next.cb_index     = s1_entry_reg.cb_index;
        out_data_next.cr_index     = s1_entry_reg.cr_index;
        out_data_next.last_pixel   = s1_entry_reg.last_pixel;
        if (s1_entry_reg.chroma_valid) begin
            out_data_next.chroma_blue = s1_cb_reg[rgb2yuv_pkg::SUM_W-1:rgb2yuv_pkg::COMP_W];
            out_data_next.chroma_red  = s1_cr_reg[rgb2yuv_pkg::SUM_W-1:rgb2yuv_pkg::COMP_W];
        end else begin
            out_data_next.chroma_blue = '0;
            out_data_next.chroma_red  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_entry_reg <= q_data;
            s1_y_reg     <= y_sum;
            s1_cb_reg    <= cb_sum;
            s1_cr_reg    <= cr_sum;
        end
        if (s1_move) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

>>> src/rgb_to_yuv420_planar.sv
// Top level of the RGB to planar YUV 4:2:0 converter with its configuration registers.
//
//   Channel   Direction   Handshake          Beat
//   s_        in          s_valid/s_ready    one pixel: blue, green, red
//   m_        out         m_valid/m_ready    one result: luma, chroma and plane indices
//   cfg_      in          cfg_wr_en          one register write, no wait
//
// One pixel is accepted per clock while the queue is not full; on its way to the output a
// result is registered in order: the front end writes the queue, the color matrix stage
// registers the sums, and the result register drives the output.
// Reset clears the raster counters, the queue and both pipeline stages.
// A stall on the output fills the pipeline and then the queue; s_ready falls only when
// the queue is full.
`default_nettype none

module rgb_to_yuv420_planar #(
    parameter int unsigned MAX_WIDTH = rgb2yuv_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = rgb2yuv_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rgb2yuv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire rgb2yuv_pkg::pixel_t                 s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output rgb2yuv_pkg::result_t                     m_data
);

    localparam int unsigned ENTRY_W = $bits(rgb2yuv_pkg::entry_t);

    rgb2yuv_pkg::cfg_t        cfg_reg;
    logic                     q_push;
    rgb2yuv_pkg::entry_t      q_push_data;
    logic                     q_pop;
    logic [ENTRY_W-1:0]       q_pop_bits;
    rgb2yuv_pkg::entry_t      q_pop_data;
    rgb2yuv_pkg::queue_stat_t q_stat;
    logic                     front_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width <= rgb2yuv_pkg::DIM_W'(2);
            cfg_reg.row_count   <= rgb2yuv_pkg::DIM_W'(2);
            cfg_reg.luma_base   <= '0;
            cfg_reg.cb_base     <= '0;
            cfg_reg.cr_base     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rgb2yuv_pkg::CFG_FRAME_WIDTH: begin
                    cfg_reg.frame_width <= cfg_data[rgb2yuv_pkg::DIM_W-1:0];
                end
                rgb2yuv_pkg::CFG_ROW_COUNT: begin
                    cfg_reg.row_count <= cfg_data[rgb2yuv_pkg::DIM_W-1:0];
                end
                rgb2yuv_pkg::CFG_LUMA_BASE: begin
                    cfg_reg.luma_base <= cfg_data[rgb2yuv_pkg::INDEX_W-1:0];
                end
                rgb2yuv_pkg::CFG_CB_BASE: begin
                    cfg_reg.cb_base <= cfg_data[rgb2yuv_pkg::INDEX_W-1:0];
                end
                rgb2yuv_pkg::CFG_CR_BASE: begin
                    cfg_reg.cr_base <= cfg_data[rgb2yuv_pkg::INDEX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rgb2yuv_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (front_ready),
        .s_data     (s_data),
        .push_ready (!q_stat.full),
        .push_valid (q_push),
        .push_data  (q_push_data)
    );

    rgb2yuv_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (rgb2yuv_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push && front_ready),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_bits),
        .stat      (q_stat)
    );

    assign q_pop_data = rgb2yuv_pkg::entry_t'(q_pop_bits);
    assign s_ready    = front_ready;

    rgb2yuv_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (!q_stat.empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && front_ready) |-> !q_stat.full)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("Queue read while empty.");

    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.chroma_valid) |->
        (m_data.chroma_blue == '0 && m_data.chroma_red == '0 &&
         m_data.cb_index == '0 && m_data.cr_index == '0))
        else $error("Chroma fields not cleared on a luma-only beat.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && q_stat.empty))
        else $error("Pipeline not empty after reset.");

endmodule

`default_nettype wire
